/* rtl/rti_pkg.sv */
// Shared widths, character codes and beat type for the radix text to integer converter.
package rti_pkg;

    localparam int CHAR_W              = 8;
    localparam int RADIX_W             = 6;
    localparam int OUT_W               = 64;
    localparam int DEFAULT_VALUE_WIDTH = 64;

    localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UP_A   = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_X   = 8'h58;
    localparam logic [CHAR_W-1:0] CH_UP_Z   = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LOW_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOW_X  = 8'h78;
    localparam logic [CHAR_W-1:0] CH_LOW_Z  = 8'h7A;

    localparam logic [RADIX_W-1:0] BASE_OCT = 6'd8;
    localparam logic [RADIX_W-1:0] BASE_DEC = 6'd10;
    localparam logic [RADIX_W-1:0] BASE_HEX = 6'd16;

    // One input beat as held in the input register.
    typedef struct packed {
        logic [CHAR_W-1:0] text_char;
        logic              end_of_text;
    } in_beat_t;

endpackage

/* rtl/rti_in_reg.sv */
// Input register stage that holds one character beat until the parser takes it.
module rti_in_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,
    input  logic              s_axis_tlast,
    input  logic              take,
    output logic              beat_valid,
    output rti_pkg::in_beat_t beat
);
    import rti_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_beat_t beat_reg;

    assign s_axis_tready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_axis_tvalid && s_axis_tready)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            beat_reg.text_char   <= s_axis_tdata;
            beat_reg.end_of_text <= s_axis_tlast;
        end
    end

    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

endmodule

/* rtl/rti_core.sv */
// Parser state machine, accumulator and result register.
module rti_core #(
    parameter int VALUE_WIDTH = rti_pkg::DEFAULT_VALUE_WIDTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [rti_pkg::RADIX_W-1:0] radix,
    input  logic                        beat_valid,
    input  rti_pkg::in_beat_t           beat,
    output logic                        take,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [rti_pkg::OUT_W-1:0]   m_axis_tdata
);
    import rti_pkg::*;

    typedef enum logic [2:0] {
        PH_FIRST,
        PH_UFIRST,
        PH_BODY,
        PH_ZERO,
        PH_HEXPFX,
        PH_FIXZERO,
        PH_DIGITS
    } phase_t;

    typedef struct packed {
        logic               ok;
        logic [RADIX_W-1:0] value;
    } digit_t;

    function automatic digit_t decode(input logic [CHAR_W-1:0] c, input logic [RADIX_W-1:0] b);
        digit_t             d;
        logic [CHAR_W-1:0]  raw;
        raw     = '0;
        d.ok    = 1'b0;
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            raw  = c - CH_ZERO;
            d.ok = 1'b1;
        end
        else if (b > BASE_DEC && c >= CH_LOW_A && c <= CH_LOW_Z)
        begin
            raw  = c - CH_LOW_A + CHAR_W'(BASE_DEC);
            d.ok = 1'b1;
        end
        else if (b > BASE_DEC && c >= CH_UP_A && c <= CH_UP_Z)
        begin
            raw  = c - CH_UP_A + CHAR_W'(BASE_DEC);
            d.ok = 1'b1;
        end
        d.value = raw[RADIX_W-1:0];
        d.ok    = d.ok && (d.value < b);
        return d;
    endfunction

    phase_t                   phase_reg, phase_next;
    logic [VALUE_WIDTH-1:0]   acc_reg, acc_next;
    logic                     outer_reg, outer_next;
    logic                     inner_reg, inner_next;
    logic [RADIX_W-1:0]       base_reg, base_next;
    logic                     stopped_reg, stopped_next;
    logic                     out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]         out_data_reg, out_data_next;

    logic                     is_minus;
    logic                     is_x;
    logic [RADIX_W-1:0]       start_base_in;
    phase_t                   start_phase;
    logic [RADIX_W-1:0]       start_base;
    logic                     start_digit;
    logic                     do_digit;
    digit_t                   dig;
    logic [VALUE_WIDTH-1:0]   acc_mac;
    logic signed [VALUE_WIDTH-1:0] signed_val;
    logic signed [OUT_W-1:0]  result;

    // An end beat needs the result register; characters never stall.
    assign take = beat_valid && (!beat.end_of_text || !out_valid_reg || m_axis_tready);

    assign is_minus = (beat.text_char == CH_MINUS);
    assign is_x     = (beat.text_char == CH_LOW_X) || (beat.text_char == CH_UP_X);

    // First character after the signs: pick the base and decide on a prefix.
    always_comb
    begin
        start_base_in = (phase_reg == PH_BODY) ? base_reg : radix;
        start_base    = start_base_in;
        start_phase   = PH_DIGITS;
        start_digit   = 1'b1;
        if (start_base_in == '0)
        begin
            if (beat.text_char == CH_ZERO)
            begin
                start_phase = PH_ZERO;
                start_digit = 1'b0;
            end
            else
            begin
                start_base = BASE_DEC;
            end
        end
        else if (phase_reg != PH_BODY && beat.text_char == CH_ZERO)
        begin
            start_phase = PH_FIXZERO;
            start_digit = 1'b0;
        end
    end

    assign signed_val = (outer_reg != inner_reg) ? -acc_reg : acc_reg;
    assign result     = OUT_W'(signed_val);

    always_comb
    begin
        phase_next     = phase_reg;
        acc_next       = acc_reg;
        outer_next     = outer_reg;
        inner_next     = inner_reg;
        base_next      = base_reg;
        stopped_next   = stopped_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        do_digit       = 1'b0;

        if (take)
        begin
            if (beat.end_of_text)
            begin
                out_valid_next = 1'b1;
                out_data_next  = result;
                phase_next     = PH_FIRST;
                acc_next       = '0;
                outer_next     = 1'b0;
                inner_next     = 1'b0;
                base_next      = '0;
                stopped_next   = 1'b0;
            end
            else
            begin
                case (phase_reg)
                    PH_FIRST:
                    begin
                        if (is_minus)
                        begin
                            outer_next = 1'b1;
                            phase_next = PH_UFIRST;
                        end
                        else
                        begin
                            base_next  = start_base;
                            phase_next = start_phase;
                            do_digit   = start_digit;
                        end
                    end
                    PH_UFIRST:
                    begin
                        if (is_minus)
                        begin
                            base_next  = radix;
                            inner_next = 1'b1;
                            phase_next = PH_BODY;
                        end
                        else
                        begin
                            base_next  = start_base;
                            phase_next = start_phase;
                            do_digit   = start_digit;
                        end
                    end
                    PH_BODY:
                    begin
                        base_next  = start_base;
                        phase_next = start_phase;
                        do_digit   = start_digit;
                    end
                    PH_ZERO:
                    begin
                        if (is_x)
                        begin
                            base_next  = BASE_HEX;
                            phase_next = PH_HEXPFX;
                        end
                        else
                        begin
                            base_next  = BASE_OCT;
                            phase_next = PH_DIGITS;
                            do_digit   = 1'b1;
                        end
                    end
                    PH_HEXPFX:
                    begin
                        phase_next = PH_DIGITS;
                        do_digit   = 1'b1;
                    end
                    PH_FIXZERO:
                    begin
                        phase_next = PH_DIGITS;
                        do_digit   = !is_x;
                    end
                    default:
                    begin
                        do_digit = 1'b1;
                    end
                endcase
            end
        end

        dig     = decode(beat.text_char, base_next);
        acc_mac = acc_reg * VALUE_WIDTH'(base_next) + VALUE_WIDTH'(dig.value);
        if (do_digit && !stopped_reg)
        begin
            if (dig.ok)
            begin
                acc_next = acc_mac;
            end
            else
            begin
                stopped_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_FIRST;
            acc_reg       <= '0;
            outer_reg     <= 1'b0;
            inner_reg     <= 1'b0;
            base_reg      <= '0;
            stopped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            acc_reg       <= acc_next;
            outer_reg     <= outer_next;
            inner_reg     <= inner_next;
            base_reg      <= base_next;
            stopped_reg   <= stopped_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

/* rtl/radix_text_to_integer.sv */
// Top level of the radix text to integer converter.
//
//  Channel   Direction  Beat contents
//  s_axis    in         tdata[7:0] text_char; tlast end_of_text
//  m_axis    out        tdata[63:0] parsed_value
//  cfg       in         cfg_wdata[5:0] radix, written when cfg_wen is high
//
// One character beat is taken every cycle while no end beat waits; the
// work per beat is one multiply-add of the accumulator by the base between
// the input register and the parser state. The result register loads when
// the parser takes the end beat from the input register and offers the result.
// Reset clears the radix to zero and the parser to the start of a string.
// Only an end beat waits, and only while the previous result is not taken.
module radix_text_to_integer #(
    parameter int VALUE_WIDTH = rti_pkg::DEFAULT_VALUE_WIDTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,   // [7:0] text_char
    input  logic                        s_axis_tlast,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [rti_pkg::OUT_W-1:0]   m_axis_tdata,   // [63:0] parsed_value
    input  logic                        cfg_wen,
    input  logic [rti_pkg::RADIX_W-1:0] cfg_wdata
);
    import rti_pkg::*;

    logic [RADIX_W-1:0] radix_reg;
    logic               beat_valid;
    in_beat_t           beat;
    logic               take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= '0;
        end
        else if (cfg_wen)
        begin
            radix_reg <= cfg_wdata;
        end
    end

    rti_in_reg u_in_reg (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .take          (take),
        .beat_valid    (beat_valid),
        .beat          (beat)
    );

    rti_core #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .radix         (radix_reg),
        .beat_valid    (beat_valid),
        .beat          (beat),
        .take          (take),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
